// ===== src/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO core.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CAP_W     = 11;
    localparam int CNT_W     = 10;
    localparam int BYTE_W    = 8;
    localparam int CAP_RESET = 1024;
    localparam int CAP_MIN   = 2;

    localparam int XW_A = (CAP_W > ADDR_W + 1) ? CAP_W : ADDR_W + 1;
    localparam int XW   = (XW_A > CNT_W + 1) ? XW_A : CNT_W + 1;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_SKIP  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        logic cfg_we;
        logic load;
        logic commit;
        logic ok;
        logic do_push;
        logic do_pop;
        logic do_skip;
        logic do_clear;
    } brf_ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic skip_ok;
    } brf_stat_t;

endpackage

`default_nettype wire

// ===== src/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/brf_dp.sv =====
// ----------------------------------------------------------------------------
// brf_dp
// Datapath: capacity register, ring pointers, fill count, storage and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_dp
    import brf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire brf_ctl_t             ctl,
    output brf_stat_t                 stat,
    input  wire logic [CAP_W-1:0]     cfg_data,
    input  wire logic [1:0]           in_cmd,
    input  wire logic [BYTE_W-1:0]    in_data,
    input  wire logic [CNT_W-1:0]     in_skip,
    output logic      [BYTE_W-1:0]    out_byte,
    output logic                      out_ok,
    output logic      [CNT_W-1:0]     out_fill,
    output logic      [CNT_W-1:0]     out_free
);

    logic [CAP_W-1:0]  cap_reg;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] fill_reg, fill_next;

    cmd_t              cmd_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [CNT_W-1:0]  skip_reg;

    logic [BYTE_W-1:0] byte_reg;
    logic              ok_reg;
    logic [CNT_W-1:0]  fill_out_reg;
    logic [CNT_W-1:0]  free_out_reg;

    logic [XW-1:0] cap_ext, cap_use;
    logic [XW-1:0] fill_ext, skip_ext;
    logic [XW-1:0] wr_inc, rd_inc, rd_skip;
    logic [XW-1:0] wr_wrap, rd_wrap, rd_skip_wrap;
    logic [XW-1:0] free_ext;
    logic [BYTE_W-1:0] ram_rdata;

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctl.do_push),
        .waddr (wr_ptr_reg),
        .wdata (data_reg),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        cap_ext = XW'(cap_reg);
        if (cap_ext < XW'(CAP_MIN)) begin
            cap_use = XW'(CAP_MIN);
        end else if (cap_ext > XW'(DEPTH)) begin
            cap_use = XW'(DEPTH);
        end else begin
            cap_use = cap_ext;
        end

        fill_ext = XW'(fill_reg);
        skip_ext = XW'(skip_reg);

        wr_inc  = XW'(wr_ptr_reg) + XW'(1);
        wr_wrap = (wr_inc >= cap_use) ? '0 : wr_inc;
        rd_inc  = XW'(rd_ptr_reg) + XW'(1);
        rd_wrap = (rd_inc >= cap_use) ? '0 : rd_inc;
        rd_skip = XW'(rd_ptr_reg) + skip_ext;
        rd_skip_wrap = (rd_skip >= cap_use) ? rd_skip - cap_use : rd_skip;

        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (ctl.do_push) begin
            wr_ptr_next = ADDR_W'(wr_wrap);
            fill_next   = ADDR_W'(fill_ext + XW'(1));
        end
        if (ctl.do_pop) begin
            rd_ptr_next = ADDR_W'(rd_wrap);
            fill_next   = ADDR_W'(fill_ext - XW'(1));
        end
        if (ctl.do_skip) begin
            rd_ptr_next = ADDR_W'(rd_skip_wrap);
            fill_next   = ADDR_W'(fill_ext - skip_ext);
        end
        if (ctl.do_clear) begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
        end

        free_ext = cap_use - XW'(1) - XW'(fill_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_W'(CAP_RESET);
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end else if (ctl.cfg_we) begin
            cap_reg    <= cfg_data;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg  <= cmd_t'(in_cmd);
            data_reg <= in_data;
            skip_reg <= in_skip;
        end
        if (ctl.commit) begin
            byte_reg     <= ctl.do_pop ? ram_rdata : '0;
            ok_reg       <= ctl.ok;
            fill_out_reg <= CNT_W'(fill_next);
            free_out_reg <= CNT_W'(free_ext);
        end
    end

    assign stat.cmd     = cmd_reg;
    assign stat.empty   = (fill_reg == '0);
    assign stat.full    = (fill_ext == cap_use - XW'(1));
    assign stat.skip_ok = (skip_ext <= fill_ext);

    assign out_byte = byte_reg;
    assign out_ok   = ok_reg;
    assign out_fill = fill_out_reg;
    assign out_free = free_out_reg;

endmodule

`default_nettype wire

// ===== src/brf_ctrl.sv =====
// ----------------------------------------------------------------------------
// brf_ctrl
// Controller: input handshake, command decode and result slot ownership.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ctrl
    import brf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire brf_stat_t stat,
    output brf_ctl_t       ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   ok;

    always_comb begin
        case (stat.cmd)
            CMD_PUSH:  ok = !stat.full;
            CMD_POP:   ok = !stat.empty;
            CMD_SKIP:  ok = stat.skip_ok;
            CMD_CLEAR: ok = 1'b1;
            default:   ok = 1'b0;
        endcase
    end

    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        ctl          = '0;
        ctl.cfg_we   = cfg_valid && (state_reg == ST_IDLE);
        ctl.load     = s_tvalid && (state_reg == ST_IDLE);
        ctl.commit   = (state_reg == ST_EXEC) && slot_free;
        ctl.ok       = ok;
        ctl.do_push  = ctl.commit && ok && (stat.cmd == CMD_PUSH);
        ctl.do_pop   = ctl.commit && ok && (stat.cmd == CMD_POP);
        ctl.do_skip  = ctl.commit && ok && (stat.cmd == CMD_SKIP);
        ctl.do_clear = ctl.commit && (stat.cmd == CMD_CLEAR);

        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (ctl.load) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (ctl.commit) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;

`ifndef ASSERT_OFF
    a_commit_fills_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.commit |=> out_valid_reg)
        else $error("result slot not loaded after commit");

    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctl.do_push, ctl.do_pop, ctl.do_skip, ctl.do_clear}))
        else $error("more than one pointer action at once");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.do_push |-> !stat.full)
        else $error("push into a full ring");

    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> !stat.empty)
        else $error("ring reports full and empty");

    a_no_slot_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !ctl.commit)
        else $error("commit over an untaken result");
`endif

endmodule

`default_nettype wire

// ===== src/byte_ring_fifo_core.sv =====
// Order: an accepted item is held in the command registers and executed in
// the execute state once the result slot is free, which registers its result.
// No new item is taken until the last one has executed; a stalled result
// holds the execute step. Reset: capacity 1024, read/write pointers and fill
// zero, no result pending; storage is left undefined and is never cleared.
// ----------------------------------------------------------------------------
// byte_ring_fifo_core
// Byte ring FIFO with configurable capacity, one slot kept empty.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_core
    import brf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // data_in[7:0], skip_count[17:8], zero
    input  wire logic [1:0]           s_tuser,   // cmd[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // read_byte[7:0], fill_count[17:8],
                                                 // free_count[27:18], zero
    output logic      [0:0]           m_tuser,   // success[0]
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CAP_W-1:0]     cfg_data   // ring_capacity
);

    brf_ctl_t  ctl;
    brf_stat_t stat;

    logic [BYTE_W-1:0] out_byte;
    logic              out_ok;
    logic [CNT_W-1:0]  out_fill;
    logic [CNT_W-1:0]  out_free;

    brf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    brf_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .stat     (stat),
        .cfg_data (cfg_data),
        .in_cmd   (s_tuser),
        .in_data  (s_tdata[BYTE_W-1:0]),
        .in_skip  (s_tdata[BYTE_W+CNT_W-1:BYTE_W]),
        .out_byte (out_byte),
        .out_ok   (out_ok),
        .out_fill (out_fill),
        .out_free (out_free)
    );

    assign m_tdata = {{(M_TDATA_W - BYTE_W - 2*CNT_W){1'b0}}, out_free, out_fill, out_byte};
    assign m_tuser = out_ok;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_core testbench
// Drives push, pop, discard and clear items through the stream port over
// several ring capacities. Each accepted item is predicted against a local
// ring model, and each result is checked field by field. Both sides idle at
// random, and one long receiver stall backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import brf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT  = 400000;
    localparam int STALL_AT   = 60;
    localparam int STALL_LEN  = 400;
    localparam int NUM_PHASES = 8;

    typedef struct {
        cmd_t              cmd;
        logic [BYTE_W-1:0] din;
        logic [CNT_W-1:0]  skip;
    } fifo_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rd_byte;
        logic              ok;
        logic [CNT_W-1:0]  fill;
        logic [CNT_W-1:0]  room;
    } fifo_resp_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data  = '0;

    byte_ring_fifo_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ring model state
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    logic [CAP_W-1:0]  cap_reg = CAP_W'(CAP_RESET);
    int                rd_ptr  = 0;
    int                wr_ptr  = 0;

    fifo_req_t  pend_q [$];
    fifo_resp_t resp_q [$];
    int         n_queued     = 0;
    int         n_taken      = 0;
    int         n_errs       = 0;
    int         cycles       = 0;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    logic       in_took      = 1'b0;
    int         hold_left    = 0;
    logic       stall_done   = 1'b0;
    fifo_req_t  drv_item;
    fifo_req_t  mon_item;
    fifo_resp_t want;
    fifo_resp_t got;

    function automatic int cap_eff(input logic [CAP_W-1:0] c);
        if (c < CAP_MIN) return CAP_MIN;
        if (c > DEPTH) return DEPTH;
        return int'(c);
    endfunction

    function automatic int ring_fill(input int cap);
        if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
        return cap - rd_ptr + wr_ptr;
    endfunction

    function automatic fifo_resp_t ring_apply(input fifo_req_t rq);
        int         cap;
        int         nxt;
        int         fill;
        fifo_resp_t r;
        cap = cap_eff(cap_reg);
        r   = '0;
        case (rq.cmd)
            CMD_PUSH: begin
                nxt = wr_ptr + 1;
                if (nxt >= cap) nxt = 0;
                if (nxt != rd_ptr) begin
                    ring_mem[wr_ptr] = rq.din;
                    wr_ptr = nxt;
                    r.ok = 1'b1;
                end
            end
            CMD_POP: begin
                if (rd_ptr != wr_ptr) begin
                    r.rd_byte = ring_mem[rd_ptr];
                    nxt = rd_ptr + 1;
                    if (nxt >= cap) nxt = 0;
                    rd_ptr = nxt;
                    r.ok = 1'b1;
                end
            end
            CMD_SKIP: begin
                if (int'(rq.skip) <= ring_fill(cap)) begin
                    nxt = rd_ptr + int'(rq.skip);
                    if (nxt >= cap) nxt -= cap;
                    rd_ptr = nxt;
                    r.ok = 1'b1;
                end
            end
            default: begin
                rd_ptr = 0;
                wr_ptr = 0;
                r.ok = 1'b1;
            end
        endcase
        fill   = ring_fill(cap);
        r.fill = CNT_W'(fill);
        r.room = CNT_W'(cap - 1 - fill);
        return r;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_took) begin
            if (pend_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                drv_item = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_item.cmd;
                s_tdata  <= {6'b0, drv_item.skip, drv_item.din};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off once traffic is flowing
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!stall_done && n_taken >= STALL_AT) begin
            m_tready   <= 1'b0;
            hold_left  <= STALL_LEN;
            stall_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_took <= 1'b0;
            cap_reg = CAP_W'(CAP_RESET);
            rd_ptr  = 0;
            wr_ptr  = 0;
        end else begin
            in_took <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                cap_reg = cfg_data;
                rd_ptr  = 0;
                wr_ptr  = 0;
            end
            if (s_tvalid && s_tready) begin
                mon_item.cmd  = cmd_t'(s_tuser);
                mon_item.din  = s_tdata[7:0];
                mon_item.skip = s_tdata[17:8];
                resp_q.push_back(ring_apply(mon_item));
                n_taken++;
            end
            if (m_tvalid && m_tready) begin
                got.rd_byte = m_tdata[7:0];
                got.fill    = m_tdata[17:8];
                got.room    = m_tdata[27:18];
                got.ok      = m_tuser[0];
                if (resp_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                    n_errs++;
                end else begin
                    want = resp_q.pop_front();
                    if (got.rd_byte !== want.rd_byte) begin
                        $display("%0t: read_byte expected %h actual %h",
                                 $time, want.rd_byte, got.rd_byte);
                        n_errs++;
                    end
                    if (got.ok !== want.ok) begin
                        $display("%0t: success expected %b actual %b",
                                 $time, want.ok, got.ok);
                        n_errs++;
                    end
                    if (got.fill !== want.fill) begin
                        $display("%0t: fill_count expected %0d actual %0d",
                                 $time, want.fill, got.fill);
                        n_errs++;
                    end
                    if (got.room !== want.room) begin
                        $display("%0t: free_count expected %0d actual %0d",
                                 $time, want.room, got.room);
                        n_errs++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("byte_ring_fifo_core regression: fail");
            $finish;
        end
    end

    task automatic enqueue(input cmd_t cmd, input int din, input int skip);
        fifo_req_t rq;
        rq.cmd  = cmd;
        rq.din  = BYTE_W'(din);
        rq.skip = CNT_W'(skip);
        pend_q.push_back(rq);
        n_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (n_taken != n_queued || resp_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic cap_write(input int value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= CAP_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph_cap [NUM_PHASES];
        int ph_len [NUM_PHASES];
        int cap;
        int bias;
        int push_pct;
        int pop_pct;
        int r;
        int sel;
        int skip;
        cmd_t cmd;

        ph_cap = '{1024, 3, 1, 0, 0, 2, 0, 0};
        ph_len = '{160, 90, 80, 110, 100, 90, 150, 145};
        ph_cap[3] = $urandom_range(5, 64);
        ph_cap[4] = $urandom_range(1025, 2047);
        ph_cap[6] = $urandom_range(65, 1023);
        ph_cap[7] = $urandom_range(2, 16);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        src_idle_pct = 34;
        snk_idle_pct = 45;

        // small ring: full, empty, overrun, wrap and clear
        cap_write(4);
        enqueue(CMD_PUSH, 8'h00, 0);
        enqueue(CMD_PUSH, 8'hff, 1023);
        enqueue(CMD_PUSH, 8'ha5, 0);
        enqueue(CMD_PUSH, 8'h3c, 0);
        enqueue(CMD_SKIP, 8'hff, 1023);
        enqueue(CMD_SKIP, 8'h00, 0);
        enqueue(CMD_POP,  8'h00, 0);
        enqueue(CMD_SKIP, 8'h00, 2);
        enqueue(CMD_POP,  8'hff, 1023);
        enqueue(CMD_PUSH, 8'h5a, 0);
        enqueue(CMD_PUSH, 8'h81, 0);
        enqueue(CMD_POP,  8'h00, 0);
        enqueue(CMD_SKIP, 8'h00, 1);
        enqueue(CMD_SKIP, 8'h00, 1);
        enqueue(CMD_PUSH, 8'h7e, 0);
        enqueue(CMD_CLEAR, 8'hff, 1023);
        enqueue(CMD_POP,  8'h00, 0);
        enqueue(CMD_CLEAR, 8'h00, 0);

        // capacity below the minimum acts as two slots
        cap_write(0);
        enqueue(CMD_PUSH, 8'h11, 0);
        enqueue(CMD_PUSH, 8'h22, 0);
        enqueue(CMD_POP,  8'h00, 0);
        enqueue(CMD_POP,  8'h00, 0);

        // capacity above the maximum acts as the full depth
        cap_write(2047);
        enqueue(CMD_PUSH, 8'hff, 0);
        enqueue(CMD_SKIP, 8'h00, 1023);
        enqueue(CMD_POP,  8'h00, 0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            cap_write(ph_cap[p]);
            if (p < 3) begin
                src_idle_pct = 34;
                snk_idle_pct = 45;
            end else if (p < 6) begin
                src_idle_pct = 45;
                snk_idle_pct = 34;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            cap = cap_eff(CAP_W'(ph_cap[p]));
            for (int k = 0; k < ph_len[p]; k++) begin
                if (k % 20 == 0) bias = $urandom_range(0, 2);
                push_pct = (bias == 0) ? 65 : (bias == 1) ? 25 : 42;
                pop_pct  = (bias == 0) ? 20 : (bias == 1) ? 60 : 42;
                r = $urandom_range(0, 99);
                if (r < push_pct) cmd = CMD_PUSH;
                else if (r < push_pct + pop_pct) cmd = CMD_POP;
                else if (r < 97) cmd = CMD_SKIP;
                else cmd = CMD_CLEAR;
                sel = $urandom_range(0, 9);
                if (sel < 6) skip = $urandom_range(0, 3);
                else if (sel < 9) skip = $urandom_range(0, cap);
                else skip = $urandom_range(0, 1023);
                enqueue(cmd, $urandom_range(0, 255), skip);
            end
        end

        wait_drained();
        repeat (20) @(negedge aclk);
        if (n_errs == 0) begin
            $display("byte_ring_fifo_core regression: pass");
        end else begin
            $display("byte_ring_fifo_core regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
